// ===== hw/rtl/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg: changed-block tracking map shared types and constants
// Request and result payloads, command and status codes, field widths and
// register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int START_W  = 48;
  localparam int SCOUNT_W = 32;
  localparam int STATUS_W = 2;
  localparam int SNAP_W   = 8;
  localparam int SHIFT_W  = 6;
  localparam int COUNT_W  = 17;
  // Sector position plus count needs one bit more than the start sector
  localparam int POS_W    = START_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COUNT_W;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 6'd7;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 17'd65536;

  // Default map depth
  localparam int MAX_BLOCKS_DEF = 65536;

  // Active number restarts at one when it reaches this value
  localparam logic [SNAP_W:0] SNAP_WRAP = 9'd256;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MARK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_BOTH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SWITCH    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BEYOND  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [START_W-1:0]  first_sector;
    logic [SCOUNT_W-1:0] sector_count;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SNAP_W-1:0]   write_entry;
    logic [SNAP_W-1:0]   read_entry;
    logic [SNAP_W-1:0]   active_number;
    logic [SNAP_W-1:0]   previous_number;
    logic                corrupted;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cbt_ram.sv =====
// ----------------------------------------------------------------------------
// cbt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/changed_block_tracking_map_top.sv =====
// ----------------------------------------------------------------------------
// changed_block_tracking_map_top: changed-block tracking map
// Write map and read map of snapshot numbers, one entry per tracking block,
// with mark, mark-both, switch, clear and read commands.
// ----------------------------------------------------------------------------
// One request at a time. A read looks up both maps through S_RDWAIT, and a
// read out of range goes straight from S_CALC to S_DONE. A mark works out its
// block range, then walks the tracking blocks covered below the count; it
// skips the walk when none is covered, and goes straight from S_CALC to S_DONE
// when it is refused or the sector count is zero. A switch walks the blocks in
// use (min of block_count and MAX_BLOCKS) and skips the walk when none is in
// use; a clear walks all MAX_BLOCKS entries; unused commands go straight from
// S_CALC to S_DONE. The next request can be taken in the cycle in which the
// previous result appears. The walk rate is set by the maps' single read port
// and single write port: one entry is read, raised, copied or zeroed, and
// written back per cycle, pipelined over consecutive entries. After reset both
// maps are zeroed by a pass during which item_stall stays high; configuration
// writes are taken at any time. A finished result sits in an output register,
// so the next request can be taken while the previous result is still stalled.
`default_nettype none

module changed_block_tracking_map_top #(
  parameter int MAX_BLOCKS = cbt_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Request channel
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire cbt_pkg::item_t                      item,
  // Result channel
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output cbt_pkg::result_t                         result,
  // Configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cbt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cbt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import cbt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_BLOCKS);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CALC   = 8'b0000_0010,
    S_RANGE  = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_WALK   = 8'b0001_0000,
    S_FLUSH  = 8'b0010_0000,
    S_RDWAIT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  // What the walk does to each entry
  typedef struct packed {
    logic raise_w;   // raise write map to active number
    logic raise_r;   // raise read map to previous number
    logic copy;      // copy write map into read map
    logic zero_w;    // zero write map
    logic zero_all;  // zero both maps
  } walk_op_t;

  localparam walk_op_t OP_IDLE     = '{default: 1'b0};
  localparam walk_op_t OP_COPY     = '{copy: 1'b1, default: 1'b0};
  localparam walk_op_t OP_ZERO_W   = '{zero_w: 1'b1, default: 1'b0};
  localparam walk_op_t OP_ZERO_ALL = '{zero_all: 1'b1, default: 1'b0};

  state_t               state;
  walk_op_t             op;
  logic                 respond;

  // Registers and snapshot state
  logic [SHIFT_W-1:0]   block_shift;
  logic [COUNT_W-1:0]   block_count;
  logic [SNAP_W-1:0]    active_snap;
  logic [SNAP_W-1:0]    previous_snap;
  logic                 corrupt_flag;

  // Request and range
  item_t                req;
  logic [POS_W-1:0]     first_blk;
  logic [POS_W-1:0]     last_sec;
  logic [POS_W-1:0]     last_blk;

  // Walk engine
  logic [ADDR_W-1:0]    idx;
  logic [ADDR_W-1:0]    end_idx;
  logic                 wb_valid;
  logic [ADDR_W-1:0]    wb_addr;

  // Result fields
  logic [STATUS_W-1:0]  res_status;
  logic [SNAP_W-1:0]    res_wr;
  logic [SNAP_W-1:0]    res_rd;

  // Map ports
  logic [ADDR_W-1:0]    raddr;
  logic [SNAP_W-1:0]    wm_rdata;
  logic [SNAP_W-1:0]    rm_rdata;
  logic                 wm_we;
  logic                 rm_we;
  logic [SNAP_W-1:0]    wm_wdata;
  logic [SNAP_W-1:0]    rm_wdata;

  // Derived values
  logic [POS_W-1:0]     bc_ext;
  logic [POS_W-1:0]     max_ext;
  logic [POS_W-1:0]     cnt_eff;
  logic [POS_W-1:0]     cnt_eff_m1;
  logic [SNAP_W:0]      snap_inc;
  logic                 over;
  logic                 nonempty;
  logic                 out_free;

  // Effective block count: min(block_count, MAX_BLOCKS)
  always_comb begin
    bc_ext     = POS_W'(block_count);
    max_ext    = POS_W'(MAX_BLOCKS);
    cnt_eff    = (bc_ext > max_ext) ? max_ext : bc_ext;
    cnt_eff_m1 = cnt_eff - POS_W'(1);
  end

  assign snap_inc = {1'b0, active_snap} + (SNAP_W+1)'(1);

  // Range checks on the block indexes
  assign over     = (last_blk >= cnt_eff);
  assign nonempty = (first_blk <= last_blk) && (first_blk < cnt_eff);

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;

  // Read address: queried block on a read, walk index otherwise
  assign raddr = (state == S_CALC) ? req.first_sector[ADDR_W-1:0] : idx;

  // Write-back of the entry read in the previous cycle
  always_comb begin
    wm_we    = wb_valid && (op.raise_w || op.zero_w || op.zero_all);
    rm_we    = wb_valid && (op.raise_r || op.copy || op.zero_all);
    if (op.zero_w || op.zero_all) begin
      wm_wdata = '0;
    end else begin
      wm_wdata = (wm_rdata < active_snap) ? active_snap : wm_rdata;
    end
    if (op.copy) begin
      rm_wdata = wm_rdata;
    end else if (op.zero_all) begin
      rm_wdata = '0;
    end else begin
      rm_wdata = (rm_rdata < previous_snap) ? previous_snap : rm_rdata;
    end
  end

  cbt_ram #(
    .WIDTH (SNAP_W),
    .DEPTH (MAX_BLOCKS)
  ) u_write_map (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wb_addr),
    .wdata (wm_wdata),
    .raddr (raddr),
    .rdata (wm_rdata)
  );

  cbt_ram #(
    .WIDTH (SNAP_W),
    .DEPTH (MAX_BLOCKS)
  ) u_read_map (
    .clk   (clk),
    .we    (rm_we),
    .waddr (wb_addr),
    .wdata (rm_wdata),
    .raddr (raddr),
    .rdata (rm_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift <= BLOCK_SHIFT_RST;
      block_count <= BLOCK_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_SHIFT: block_shift <= cfg_data[SHIFT_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.status          <= res_status;
      result.write_entry     <= res_wr;
      result.read_entry      <= res_rd;
      result.active_number   <= active_snap;
      result.previous_number <= previous_snap;
      result.corrupted       <= corrupt_flag;
    end
  end

  // Command sequencer and walk engine
  always_ff @(posedge clk) begin
    if (rst) begin
      // Zero both maps before the first request
      state         <= S_WALK;
      op            <= '{raise_w: 1'b0, raise_r: 1'b0, copy: 1'b0, zero_w: 1'b0,
                         zero_all: 1'b1};
      respond       <= 1'b0;
      idx           <= '0;
      end_idx       <= ADDR_W'(MAX_BLOCKS - 1);
      wb_valid      <= 1'b0;
      wb_addr       <= '0;
      active_snap   <= SNAP_W'(1);
      previous_snap <= '0;
      corrupt_flag  <= 1'b0;
      res_status    <= ST_OK;
      res_wr        <= '0;
      res_rd        <= '0;
    end else begin
      wb_valid <= (state == S_WALK);
      wb_addr  <= idx;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            req   <= item;
            state <= S_CALC;
          end
        end

        S_CALC: begin
          res_wr     <= '0;
          res_rd     <= '0;
          respond    <= 1'b1;
          case (req.cmd)
            CMD_MARK, CMD_MARK_BOTH: begin
              op <= OP_IDLE;
              if (corrupt_flag) begin
                res_status <= ST_CORRUPT;
                state      <= S_DONE;
              end else if (req.sector_count == '0) begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                last_sec   <= POS_W'(req.first_sector) + POS_W'(req.sector_count)
                              - POS_W'(1);
                first_blk  <= POS_W'(req.first_sector) >> block_shift;
                state      <= S_RANGE;
              end
            end
            CMD_SWITCH: begin
              res_status    <= ST_OK;
              previous_snap <= active_snap;
              if (snap_inc == SNAP_WRAP) begin
                active_snap <= SNAP_W'(1);
                op          <= OP_ZERO_W;
              end else begin
                active_snap <= snap_inc[SNAP_W-1:0];
                op          <= OP_COPY;
              end
              idx     <= '0;
              end_idx <= cnt_eff_m1[ADDR_W-1:0];
              state   <= (cnt_eff == '0) ? S_DONE : S_WALK;
            end
            CMD_CLEAR: begin
              res_status    <= ST_OK;
              active_snap   <= SNAP_W'(1);
              previous_snap <= '0;
              corrupt_flag  <= 1'b0;
              op            <= OP_ZERO_ALL;
              idx           <= '0;
              end_idx       <= ADDR_W'(MAX_BLOCKS - 1);
              state         <= S_WALK;
            end
            CMD_READ: begin
              op <= OP_IDLE;
              if (POS_W'(req.first_sector) >= cnt_eff) begin
                res_status <= ST_BEYOND;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_RDWAIT;
              end
            end
            default: begin
              op         <= OP_IDLE;
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          endcase
        end

        S_RANGE: begin
          last_blk <= last_sec >> block_shift;
          state    <= S_CHECK;
        end

        // Clip the walk at the block count; overflow is reported after it
        S_CHECK: begin
          if (over) begin
            res_status <= ST_BEYOND;
            if (req.cmd == CMD_MARK) begin
              corrupt_flag <= 1'b1;
            end
          end
          op         <= '{raise_w: 1'b1,
                          raise_r: (req.cmd == CMD_MARK_BOTH) && !over,
                          copy: 1'b0, zero_w: 1'b0, zero_all: 1'b0};
          idx        <= first_blk[ADDR_W-1:0];
          end_idx    <= over ? cnt_eff_m1[ADDR_W-1:0] : last_blk[ADDR_W-1:0];
          state      <= nonempty ? S_WALK : S_DONE;
        end

        S_WALK: begin
          if (idx == end_idx) begin
            state <= S_FLUSH;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end

        // Last entry is written back in this cycle
        S_FLUSH: begin
          state <= respond ? S_DONE : S_IDLE;
        end

        S_RDWAIT: begin
          res_wr <= wm_rdata;
          res_rd <= rm_rdata;
          state  <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
